@@ rtl/core/trdm_pkg.sv @@
package trdm_pkg;

  localparam int DW   = 16;  // depth word
  localparam int EW   = 17;  // vertex edge delta
  localparam int OW   = 18;  // pixel offset from vertex 0
  localparam int SW   = 24;  // per-pixel edge step
  localparam int NBW  = 40;  // edge function value
  localparam int ACW  = 60;  // accumulator and interpolation numerator
  localparam int NSW  = 44;  // numerator step
  localparam int DIV_STEPS = 16;

  localparam logic [DW-1:0] FAR_DEPTH = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] Z_BIAS    = 16'd16384;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    OPC_DRAW  = 2'd0,
    OPC_READ  = 2'd1,
    OPC_CLEAR = 2'd2,
    OPC_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_ZERO = 2'd1,
    K_DRAW = 2'd2,
    K_READ = 2'd3
  } out_kind_t;

  typedef enum logic [4:0] {
    M_D1  = 5'd0,
    M_D2  = 5'd1,
    M_N1A = 5'd2,
    M_N1B = 5'd3,
    M_N2A = 5'd4,
    M_N2B = 5'd5,
    M_LN2 = 5'd6,
    M_LN0 = 5'd7,
    M_Z0  = 5'd8,
    M_Z1  = 5'd9,
    M_Z2  = 5'd10,
    M_X0  = 5'd11,
    M_X1  = 5'd12,
    M_X2  = 5'd13,
    M_Y0  = 5'd14,
    M_Y1  = 5'd15,
    M_Y2  = 5'd16,
    M_END = 5'd17
  } mac_step_t;

  typedef struct packed {
    logic      load;
    logic      prep;
    logic      mac_en;
    mac_step_t step;
    logic      pix_start;
    logic      div_step;
    logic      cmp_write;
    logic      step_x;
    logic      step_y;
    logic      sweep_step;
    logic      mem_rd;
    logic      rd_probe;
    logic      out_load;
    out_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic box_empty;
    logic pix_ok;
    logic x_last;
    logic y_last;
    logic sweep_last;
  } dp_stat_t;

endpackage

@@ rtl/core/trdm_ctrl.sv @@
module trdm_ctrl import trdm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_opcode,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SWEEP = 10'b0000000010,
    S_PREP  = 10'b0000000100,
    S_SETUP = 10'b0000001000,
    S_PIX   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_CMP   = 10'b0001000000,
    S_ADV   = 10'b0010000000,
    S_READ  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t    state_r, state_nxt;
  out_kind_t kind_r, kind_nxt;
  mac_step_t step_r, step_nxt;
  logic [3:0] div_cnt_r, div_cnt_nxt;
  logic      out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.step    = step_r;
    cmd.kind    = kind_r;
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    step_nxt    = step_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (opcode_t'(in_opcode))
            OPC_DRAW: begin
              kind_nxt  = K_DRAW;
              state_nxt = S_PREP;
            end
            OPC_READ: begin
              kind_nxt  = K_READ;
              state_nxt = S_READ;
            end
            OPC_CLEAR: begin
              kind_nxt  = K_ZERO;
              state_nxt = S_SWEEP;
            end
            default: begin
              kind_nxt  = K_ZERO;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = (kind_r == K_NONE) ? S_IDLE : S_FIN;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = M_D1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.mac_en = 1'b1;
        if (step_r == M_END) begin
          state_nxt = (stat.d_zero || stat.box_empty) ? S_FIN : S_PIX;
        end else begin
          step_nxt = mac_step_t'(step_r + 5'd1);
        end
      end
      S_PIX: begin
        if (stat.pix_ok) begin
          cmd.pix_start = 1'b1;
          cmd.mem_rd    = 1'b1;
          div_cnt_nxt   = '0;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_ADV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'(DIV_STEPS - 1)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp_write = 1'b1;
        state_nxt     = S_ADV;
      end
      S_ADV: begin
        if (stat.y_last) begin
          if (stat.x_last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.step_x = 1'b1;
            state_nxt  = S_PIX;
          end
        end else begin
          cmd.step_y = 1'b1;
          state_nxt  = S_PIX;
        end
      end
      S_READ: begin
        cmd.mem_rd   = 1'b1;
        cmd.rd_probe = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      kind_r      <= K_NONE;
      step_r      <= M_D1;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      step_r      <= step_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/trdm_datapath.sv @@
module trdm_datapath import trdm_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic signed [15:0] in_vert0_x,
  input  logic signed [15:0] in_vert0_y,
  input  logic signed [15:0] in_vert0_z,
  input  logic signed [15:0] in_vert1_x,
  input  logic signed [15:0] in_vert1_y,
  input  logic signed [15:0] in_vert1_z,
  input  logic signed [15:0] in_vert2_x,
  input  logic signed [15:0] in_vert2_y,
  input  logic signed [15:0] in_vert2_z,
  input  logic [7:0]         in_probe_x,
  input  logic [7:0]         in_probe_y,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic signed [15:0] out_depth_value,
  output logic               out_is_empty,
  output logic [16:0]        out_pixels_written
);

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(ENTRIES);

  // configuration
  logic [8:0]    width_r, height_r;
  logic [XW-1:0] xmax;
  logic [YW-1:0] ymax;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == REG_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_comb begin
    if (width_r == '0) begin
      xmax = '0;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      xmax = XW'(MAX_WIDTH - 1);
    end else begin
      xmax = XW'(32'(width_r) - 32'd1);
    end
    if (height_r == '0) begin
      ymax = '0;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      ymax = YW'(MAX_HEIGHT - 1);
    end else begin
      ymax = YW'(32'(height_r) - 32'd1);
    end
  end

  // transaction capture
  logic signed [15:0] x0_r, y0_r, z0_r, x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic [7:0] probe_x_r, probe_y_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_vert0_x;
      y0_r <= in_vert0_y;
      z0_r <= in_vert0_z;
      x1_r <= in_vert1_x;
      y1_r <= in_vert1_y;
      z1_r <= in_vert1_z;
      x2_r <= in_vert2_x;
      y2_r <= in_vert2_y;
      z2_r <= in_vert2_z;
      probe_x_r <= in_probe_x;
      probe_y_r <= in_probe_y;
    end
  end

  // edges and bounding box
  logic signed [EW-1:0] ex1_c, ey1_c, ex2_c, ey2_c;
  logic signed [EW-1:0] ex1_r, ey1_r, ex2_r, ey2_r;
  logic signed [15:0]   minx, maxx, miny, maxy;
  logic signed [11:0]   fx_lo, fx_hi, fy_lo, fy_hi;
  logic [11:0]          xs_c, ys_c;
  logic signed [12:0]   xe_s, ye_s, xmax_s, ymax_s;
  logic signed [OW-1:0] dx0_c, dy0_c, dx0_r, dy0_r;
  logic                 empty_c, empty_r;
  logic [XW-1:0]        xs_r, xe_r, x_r;
  logic [YW-1:0]        ys_r, ye_r, y_r;

  assign ex1_c = EW'(x1_r) - EW'(x0_r);
  assign ey1_c = EW'(y1_r) - EW'(y0_r);
  assign ex2_c = EW'(x2_r) - EW'(x0_r);
  assign ey2_c = EW'(y2_r) - EW'(y0_r);

  always_comb begin
    minx = x0_r;
    maxx = x0_r;
    miny = y0_r;
    maxy = y0_r;
    if (x1_r < minx) minx = x1_r;
    if (x2_r < minx) minx = x2_r;
    if (x1_r > maxx) maxx = x1_r;
    if (x2_r > maxx) maxx = x2_r;
    if (y1_r < miny) miny = y1_r;
    if (y2_r < miny) miny = y2_r;
    if (y1_r > maxy) maxy = y1_r;
    if (y2_r > maxy) maxy = y2_r;
  end

  // floor of a sixteenth count is an arithmetic shift
  assign fx_lo  = minx[15:4];
  assign fx_hi  = maxx[15:4];
  assign fy_lo  = miny[15:4];
  assign fy_hi  = maxy[15:4];
  assign xs_c   = fx_lo[11] ? '0 : fx_lo;
  assign ys_c   = fy_lo[11] ? '0 : fy_lo;
  assign xmax_s = signed'(13'(xmax));
  assign ymax_s = signed'(13'(ymax));
  assign xe_s   = (13'(fx_hi) > xmax_s) ? xmax_s : 13'(fx_hi);
  assign ye_s   = (13'(fy_hi) > ymax_s) ? ymax_s : 13'(fy_hi);
  assign empty_c = (signed'({1'b0, xs_c}) > xe_s) || (signed'({1'b0, ys_c}) > ye_s);
  assign dx0_c  = signed'({2'b00, xs_c, 4'b0000}) - OW'(x0_r);
  assign dy0_c  = signed'({2'b00, ys_c, 4'b0000}) - OW'(y0_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ex1_r   <= ex1_c;
      ey1_r   <= ey1_c;
      ex2_r   <= ex2_c;
      ey2_r   <= ey2_c;
      dx0_r   <= dx0_c;
      dy0_r   <= dy0_c;
      empty_r <= empty_c;
      xs_r    <= XW'(xs_c);
      ys_r    <= YW'(ys_c);
      xe_r    <= XW'(xe_s);
      ye_r    <= YW'(ye_s);
    end
  end

  // per-pixel steps of the edge functions
  logic                 neg_r;
  logic signed [SW-1:0] t_ey1, t_ey2, t_ex1, t_ex2;
  logic signed [SW-1:0] n0x, n1x, n2x, n0y, n1y, n2y;

  assign t_ey1 = SW'(ey1_r) <<< 4;
  assign t_ey2 = SW'(ey2_r) <<< 4;
  assign t_ex1 = SW'(ex1_r) <<< 4;
  assign t_ex2 = SW'(ex2_r) <<< 4;
  assign n1x   = neg_r ? -t_ey2 : t_ey2;
  assign n2x   = neg_r ? t_ey1 : -t_ey1;
  assign n0x   = -(n1x + n2x);
  assign n1y   = neg_r ? t_ex2 : -t_ex2;
  assign n2y   = neg_r ? -t_ex1 : t_ex1;
  assign n0y   = -(n1y + n2y);

  // shared multiply-accumulate for setup
  logic signed [NBW-1:0] mac_a;
  logic signed [OW-1:0]  mac_b;
  logic                  mac_clr, mac_sub, mac_do;
  logic signed [NBW+OW-1:0] prod;
  logic signed [ACW-1:0] prod_x, acc_r, acc_nxt, acc_abs;
  logic signed [NBW-1:0] d_r, n0_r, n1_r, n2_r;
  logic signed [ACW-1:0] off_r, hi_r, nacc_r, off_c, hi_c;
  logic signed [NSW-1:0] nxs_r, nys_r;

  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_clr = 1'b0;
    mac_sub = 1'b0;
    mac_do  = 1'b1;
    case (cmd.step)
      M_D1: begin
        mac_a = NBW'(ex1_r); mac_b = OW'(ey2_r); mac_clr = 1'b1;
      end
      M_D2: begin
        mac_a = NBW'(ex2_r); mac_b = OW'(ey1_r); mac_sub = 1'b1;
      end
      M_N1A: begin
        mac_a = NBW'(ey2_r); mac_b = dx0_r; mac_clr = 1'b1;
      end
      M_N1B: begin
        mac_a = NBW'(ex2_r); mac_b = dy0_r; mac_sub = 1'b1;
      end
      M_N2A: begin
        mac_a = NBW'(ex1_r); mac_b = dy0_r; mac_clr = 1'b1;
      end
      M_N2B: begin
        mac_a = NBW'(ey1_r); mac_b = dx0_r; mac_sub = 1'b1;
      end
      M_Z0: begin
        mac_a = n0_r; mac_b = OW'(z0_r); mac_clr = 1'b1;
      end
      M_Z1: begin
        mac_a = n1_r; mac_b = OW'(z1_r);
      end
      M_Z2: begin
        mac_a = n2_r; mac_b = OW'(z2_r);
      end
      M_X0: begin
        mac_a = NBW'(n0x); mac_b = OW'(z0_r); mac_clr = 1'b1;
      end
      M_X1: begin
        mac_a = NBW'(n1x); mac_b = OW'(z1_r);
      end
      M_X2: begin
        mac_a = NBW'(n2x); mac_b = OW'(z2_r);
      end
      M_Y0: begin
        mac_a = NBW'(n0y); mac_b = OW'(z0_r); mac_clr = 1'b1;
      end
      M_Y1: begin
        mac_a = NBW'(n1y); mac_b = OW'(z1_r);
      end
      M_Y2: begin
        mac_a = NBW'(n2y); mac_b = OW'(z2_r);
      end
      default: mac_do = 1'b0;
    endcase
  end

  assign prod    = mac_a * mac_b;
  assign prod_x  = ACW'(prod);
  assign acc_nxt = (mac_clr ? '0 : acc_r) + (mac_sub ? -prod_x : prod_x);
  assign acc_abs = acc_r[ACW-1] ? -acc_r : acc_r;
  assign off_c   = ACW'(d_r) <<< 15;
  assign hi_c    = off_c + (ACW'(d_r) <<< 1);

  // walking state: p is the current pixel, c the top of the current column
  logic signed [NBW-1:0] p0_r, p1_r, p2_r, c0_r, c1_r, c2_r;
  logic signed [ACW-1:0] pn_r, cn_r;

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      if (mac_do) begin
        acc_r <= acc_nxt;
      end
      case (cmd.step)
        M_N1A: begin
          d_r   <= NBW'(acc_abs);
          neg_r <= acc_r[ACW-1];
        end
        M_N2A: n1_r <= neg_r ? -NBW'(acc_r) : NBW'(acc_r);
        M_LN2: n2_r <= neg_r ? -NBW'(acc_r) : NBW'(acc_r);
        M_LN0: begin
          n0_r  <= d_r - n1_r - n2_r;
          off_r <= off_c;
          hi_r  <= hi_c;
        end
        M_X0: nacc_r <= (acc_r <<< 1) + ACW'(d_r);
        M_Y0: nxs_r  <= NSW'(acc_r <<< 1);
        M_END: begin
          nys_r <= NSW'(acc_r <<< 1);
          p0_r  <= n0_r;
          p1_r  <= n1_r;
          p2_r  <= n2_r;
          pn_r  <= nacc_r;
          c0_r  <= n0_r;
          c1_r  <= n1_r;
          c2_r  <= n2_r;
          cn_r  <= nacc_r;
          x_r   <= xs_r;
          y_r   <= ys_r;
        end
        default: ;
      endcase
    end else if (cmd.step_y) begin
      p0_r <= p0_r + NBW'(n0y);
      p1_r <= p1_r + NBW'(n1y);
      p2_r <= p2_r + NBW'(n2y);
      pn_r <= pn_r + ACW'(nys_r);
      y_r  <= y_r + YW'(1);
    end else if (cmd.step_x) begin
      c0_r <= c0_r + NBW'(n0x);
      c1_r <= c1_r + NBW'(n1x);
      c2_r <= c2_r + NBW'(n2x);
      cn_r <= cn_r + ACW'(nxs_r);
      p0_r <= c0_r + NBW'(n0x);
      p1_r <= c1_r + NBW'(n1x);
      p2_r <= c2_r + NBW'(n2x);
      pn_r <= cn_r + ACW'(nxs_r);
      x_r  <= x_r + XW'(1);
      y_r  <= ys_r;
    end
  end

  // restoring divide of the biased numerator by twice the area
  logic signed [ACW-1:0] rem_r, dsh_r, trial;
  logic [DW-1:0]         q_r;
  logic signed [DW-1:0]  z_c;

  assign trial = rem_r - dsh_r;
  assign z_c   = signed'(q_r - Z_BIAS);

  always_ff @(posedge clk) begin
    if (cmd.pix_start) begin
      rem_r <= pn_r + off_r;
      dsh_r <= ACW'(d_r) <<< 16;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (!trial[ACW-1]) begin
        rem_r <= trial;
        q_r   <= {q_r[DW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[DW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >>> 1;
    end
  end

  // depth store
  logic [DW-1:0] mem [ENTRIES];
  logic [DW-1:0] rdata_r;
  logic [AW-1:0] pix_addr, probe_addr, raddr, waddr, sweep_r;
  logic [DW-1:0] wdata;
  logic          we, depth_pass, probe_off;
  logic [16:0]   count_r;

  assign pix_addr   = AW'(32'(y_r) * MAX_WIDTH + 32'(x_r));
  assign probe_addr = AW'(32'(probe_y_r) * MAX_WIDTH + 32'(probe_x_r));
  assign probe_off  = (32'(probe_x_r) > 32'(xmax)) || (32'(probe_y_r) > 32'(ymax));
  assign raddr      = cmd.rd_probe ? probe_addr : pix_addr;
  assign depth_pass = (z_c >= signed'(rdata_r));
  assign we         = cmd.sweep_step || (cmd.cmp_write && depth_pass);
  assign waddr      = cmd.sweep_step ? sweep_r : pix_addr;
  assign wdata      = cmd.sweep_step ? FAR_DEPTH : z_c;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      count_r <= '0;
    end else begin
      if (cmd.load) begin
        sweep_r <= '0;
        count_r <= '0;
      end else begin
        if (cmd.sweep_step) begin
          sweep_r <= sweep_r + AW'(1);
        end
        if (cmd.cmp_write && depth_pass) begin
          count_r <= count_r + 17'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.kind)
        K_DRAW: begin
          out_depth_value    <= '0;
          out_is_empty       <= 1'b0;
          out_pixels_written <= count_r;
        end
        K_READ: begin
          out_pixels_written <= '0;
          if (probe_off) begin
            out_depth_value <= signed'(FAR_DEPTH);
            out_is_empty    <= 1'b1;
          end else begin
            out_depth_value <= signed'(rdata_r);
            out_is_empty    <= (rdata_r == FAR_DEPTH);
          end
        end
        default: begin
          out_depth_value    <= '0;
          out_is_empty       <= 1'b0;
          out_pixels_written <= '0;
        end
      endcase
    end
  end

  // inside test: all weights non-negative and depth within [-1, 1]
  assign stat.pix_ok = !p0_r[NBW-1] && !p1_r[NBW-1] && !p2_r[NBW-1]
                    && (pn_r >= -off_r) && (pn_r < hi_r);
  assign stat.d_zero     = (d_r == '0);
  assign stat.box_empty  = empty_r;
  assign stat.x_last     = (x_r == xe_r);
  assign stat.y_last     = (y_r == ye_r);
  assign stat.sweep_last = (sweep_r == AW'(ENTRIES - 1));

endmodule

@@ rtl/core/triangle_depth_map_rasterizer.sv @@
// read: a probe read of the depth store, then the result; no-op: the result directly.
// clear: a sweep of every entry. draw: setup on one shared multiply-accumulate, then a
// test of each bounding-box pixel, a divide per pixel inside the triangle (16-step divider).
// one transaction in flight; the next is taken once the result sits in the output register.
// after reset the depth store is swept to the far marker, one entry per cycle
// while no input is taken; registers return to 256.
module triangle_depth_map_rasterizer import trdm_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [15:0] in_vert0_x,
  input  logic signed [15:0] in_vert0_y,
  input  logic signed [15:0] in_vert0_z,
  input  logic signed [15:0] in_vert1_x,
  input  logic signed [15:0] in_vert1_y,
  input  logic signed [15:0] in_vert1_z,
  input  logic signed [15:0] in_vert2_x,
  input  logic signed [15:0] in_vert2_y,
  input  logic signed [15:0] in_vert2_z,
  input  logic [7:0]         in_probe_x,
  input  logic [7:0]         in_probe_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_depth_value,
  output logic               out_is_empty,
  output logic [16:0]        out_pixels_written
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  trdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  trdm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_vert0_x         (in_vert0_x),
    .in_vert0_y         (in_vert0_y),
    .in_vert0_z         (in_vert0_z),
    .in_vert1_x         (in_vert1_x),
    .in_vert1_y         (in_vert1_y),
    .in_vert1_z         (in_vert1_z),
    .in_vert2_x         (in_vert2_x),
    .in_vert2_y         (in_vert2_y),
    .in_vert2_z         (in_vert2_z),
    .in_probe_x         (in_probe_x),
    .in_probe_y         (in_probe_y),
    .cmd                (cmd),
    .stat               (stat),
    .out_depth_value    (out_depth_value),
    .out_is_empty       (out_is_empty),
    .out_pixels_written (out_pixels_written)
  );

endmodule

@@ bench/testbench.sv @@
module testbench;
  import trdm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_MAX = 256;
  localparam int RANDOM_PER_PHASE = 250;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    opcode_t             op;
    logic signed [15:0]  vx [3];
    logic signed [15:0]  vy [3];
    logic signed [15:0]  vz [3];
    logic [7:0]          px;
    logic [7:0]          py;
  } raster_op_t;

  typedef struct {
    logic signed [15:0] depth;
    logic               empty;
    logic [16:0]        written;
  } raster_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic signed [15:0] in_vert0_x = '0, in_vert0_y = '0, in_vert0_z = '0;
  logic signed [15:0] in_vert1_x = '0, in_vert1_y = '0, in_vert1_z = '0;
  logic signed [15:0] in_vert2_x = '0, in_vert2_y = '0, in_vert2_z = '0;
  logic [7:0] in_probe_x = '0, in_probe_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_depth_value;
  logic out_is_empty;
  logic [16:0] out_pixels_written;

  triangle_depth_map_rasterizer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  shortint     depth_map [SCR_MAX*SCR_MAX];
  logic [8:0]  scr_w_reg = 9'd256;
  logic [8:0]  scr_h_reg = 9'd256;

  raster_op_t  pending_ops [$];
  raster_op_t  cur_op;
  raster_res_t expected_results [$];
  int          mismatches = 0;
  int          sent_count = 0;
  int          draws_seen = 0, reads_seen = 0, pixels_total = 0;
  int          idle_mode = 0;
  longint      cycle_count = 0;

  function automatic int eff_dim(logic [8:0] v);
    if (v == 0) return 1;
    if (v > SCR_MAX) return SCR_MAX;
    return int'(v);
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [16:0] rasterize(raster_op_t t);
    longint x0, y0, z0, x1, y1, z1, x2, y2, z2;
    longint d, sgn, mnx, mxx, mny, mxy, xs, xe, ys, ye, dx, dy, n0, n1, n2, s, z;
    int     w, h, cnt, addr;
    x0 = t.vx[0]; y0 = t.vy[0]; z0 = t.vz[0];
    x1 = t.vx[1]; y1 = t.vy[1]; z1 = t.vz[1];
    x2 = t.vx[2]; y2 = t.vy[2]; z2 = t.vz[2];
    w = eff_dim(scr_w_reg);
    h = eff_dim(scr_h_reg);
    cnt = 0;
    d = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
    if (d == 0) return '0;
    sgn = 1;
    if (d < 0) begin
      sgn = -1;
      d = -d;
    end
    mnx = x0; mxx = x0; mny = y0; mxy = y0;
    if (x1 < mnx) mnx = x1;
    if (x2 < mnx) mnx = x2;
    if (x1 > mxx) mxx = x1;
    if (x2 > mxx) mxx = x2;
    if (y1 < mny) mny = y1;
    if (y2 < mny) mny = y2;
    if (y1 > mxy) mxy = y1;
    if (y2 > mxy) mxy = y2;
    xs = floor_quot(mnx, 16); xe = floor_quot(mxx, 16);
    ys = floor_quot(mny, 16); ye = floor_quot(mxy, 16);
    if (xs < 0) xs = 0;
    if (ys < 0) ys = 0;
    if (xe > w - 1) xe = w - 1;
    if (ye > h - 1) ye = h - 1;
    for (longint x = xs; x <= xe; x++) begin
      for (longint y = ys; y <= ye; y++) begin
        dx = x * 16 - x0;
        dy = y * 16 - y0;
        n1 = sgn * (dx * (y2 - y0) - (x2 - x0) * dy);
        n2 = sgn * ((x1 - x0) * dy - dx * (y1 - y0));
        n0 = d - n1 - n2;
        if (n0 < 0 || n1 < 0 || n2 < 0) continue;
        s = n0 * z0 + n1 * z1 + n2 * z2;
        z = floor_quot(2 * s + d, 2 * d);
        if (z < -16384 || z > 16384) continue;
        addr = int'(y) * SCR_MAX + int'(x);
        if (z < longint'(depth_map[addr])) continue;
        depth_map[addr] = shortint'(z);
        cnt++;
      end
    end
    return 17'(cnt);
  endfunction

  function automatic raster_res_t predict_op(raster_op_t t);
    raster_res_t r;
    r.depth = '0;
    r.empty = 1'b0;
    r.written = '0;
    case (t.op)
      OPC_DRAW: r.written = rasterize(t);
      OPC_READ: begin
        if (t.px >= eff_dim(scr_w_reg) || t.py >= eff_dim(scr_h_reg)) begin
          r.depth = -16'sd32768;
          r.empty = 1'b1;
        end else begin
          r.depth = depth_map[int'(t.py) * SCR_MAX + int'(t.px)];
          r.empty = (r.depth == -16'sd32768);
        end
      end
      OPC_CLEAR: foreach (depth_map[i]) depth_map[i] = -16'sd32768;
      default: ;
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_results.push_back(predict_op(cur_op));
      if (cur_op.op == OPC_DRAW) draws_seen++;
      if (cur_op.op == OPC_READ) reads_seen++;
    end
    if (!in_valid || !in_stall) begin
      if (rst_n && pending_ops.size() > 0 &&
          !(idle_mode == 0 && $urandom_range(0, 99) < 22) &&
          !(idle_mode == 1 && $urandom_range(0, 99) < 57)) begin
        cur_op = pending_ops.pop_front();
        sent_count++;
        in_valid   <= 1'b1;
        in_opcode  <= cur_op.op;
        in_vert0_x <= cur_op.vx[0]; in_vert0_y <= cur_op.vy[0]; in_vert0_z <= cur_op.vz[0];
        in_vert1_x <= cur_op.vx[1]; in_vert1_y <= cur_op.vy[1]; in_vert1_z <= cur_op.vz[1];
        in_vert2_x <= cur_op.vx[2]; in_vert2_y <= cur_op.vy[2]; in_vert2_z <= cur_op.vz[2];
        in_probe_x <= cur_op.px;
        in_probe_y <= cur_op.py;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    raster_res_t e;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: depth %0d", out_depth_value);
      end else begin
        e = expected_results.pop_front();
        if (e.depth !== out_depth_value || e.empty !== out_is_empty ||
            e.written !== out_pixels_written) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected depth %0d empty %0b written %0d, got %0d %0b %0d",
                     e.depth, e.empty, e.written, out_depth_value, out_is_empty,
                     out_pixels_written);
        end else if (e.written != 0) begin
          pixels_total += e.written;
        end
      end
    end
    out_stall <= (idle_mode == 0) ? ($urandom_range(0, 99) < 57) :
                 (idle_mode == 1) ? ($urandom_range(0, 99) < 22) : 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic raster_op_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                          int x2, int y2, int z2);
    raster_op_t t;
    t.op = OPC_DRAW;
    t.vx[0] = 16'(x0); t.vy[0] = 16'(y0); t.vz[0] = 16'(z0);
    t.vx[1] = 16'(x1); t.vy[1] = 16'(y1); t.vz[1] = 16'(z1);
    t.vx[2] = 16'(x2); t.vy[2] = 16'(y2); t.vz[2] = 16'(z2);
    t.px = 8'($urandom); t.py = 8'($urandom);
    return t;
  endfunction

  function automatic raster_op_t make_plain(opcode_t op, int px, int py);
    raster_op_t t;
    t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    t.op = op;
    t.px = 8'(px);
    t.py = 8'(py);
    return t;
  endfunction

  function automatic int rand_depth();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 32768)) - 16384;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  int clears_left = 3;

  function automatic raster_op_t random_op(bit wild_coords);
    raster_op_t t;
    int r, w, h, cx, cy, spread;
    int vx [3], vy [3];
    w = eff_dim(scr_w_reg);
    h = eff_dim(scr_h_reg);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      if (wild_coords || $urandom_range(0, 99) < 3) begin
        for (int k = 0; k < 3; k++) begin
          vx[k] = int'($urandom_range(0, 65535)) - 32768;
          vy[k] = int'($urandom_range(0, 65535)) - 32768;
        end
        // keep the box narrow on a wide screen
        if (!wild_coords && w > 16) foreach (vx[k]) vx[k] = vx[k] % 64;
        if (!wild_coords && h > 16) foreach (vy[k]) vy[k] = vy[k] % 64;
      end else begin
        spread = ($urandom_range(0, 9) == 0) ? 120 : 50;
        cx = int'($urandom_range(0, w * 16 + 32)) - 16;
        cy = int'($urandom_range(0, h * 16 + 32)) - 16;
        for (int k = 0; k < 3; k++) begin
          vx[k] = cx + int'($urandom_range(0, 2 * spread)) - spread;
          vy[k] = cy + int'($urandom_range(0, 2 * spread)) - spread;
          // snap to pixel centers now and then to hit edges exactly
          if ($urandom_range(0, 3) == 0) begin
            vx[k] = vx[k] & ~15;
            vy[k] = vy[k] & ~15;
          end
        end
      end
      t = make_tri(vx[0], vy[0], rand_depth(), vx[1], vy[1], rand_depth(),
                   vx[2], vy[2], rand_depth());
    end else if (r < 95 || (r >= 97 && clears_left == 0)) begin
      if ($urandom_range(0, 99) < 80)
        t = make_plain(OPC_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1));
      else
        t = make_plain(OPC_READ, $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (r < 97) begin
      t = make_plain(OPC_NOP, $urandom_range(0, 255), $urandom_range(0, 255));
    end else begin
      clears_left--;
      t = make_plain(OPC_CLEAR, 0, 0);
    end
    return t;
  endfunction

  task automatic wait_idle();
    while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) scr_w_reg = val;
    else if (idx == REG_HEIGHT) scr_h_reg = val;
  endtask

  task automatic run_random(int n, bit wild_coords);
    for (int i = 0; i < n; i++) pending_ops.push_back(random_op(wild_coords));
    wait_idle();
  endtask

  initial begin
    foreach (depth_map[i]) depth_map[i] = -16'sd32768;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_WIDTH, 9'd16);
    write_reg(REG_HEIGHT, 9'd16);
    pending_ops.push_back(make_plain(OPC_READ, 0, 0));
    pending_ops.push_back(make_plain(OPC_READ, 255, 255));
    pending_ops.push_back(make_tri(16, 16, 0, 96, 16, 0, 16, 96, 0));
    pending_ops.push_back(make_tri(16, 16, 0, 96, 16, 0, 16, 96, 0));      // ties overwrite
    pending_ops.push_back(make_tri(16, 16, -100, 96, 16, -100, 16, 96, -100));
    pending_ops.push_back(make_tri(16, 96, 2000, 96, 16, 2000, 16, 16, 2000)); // other winding
    pending_ops.push_back(make_plain(OPC_READ, 2, 2));
    pending_ops.push_back(make_tri(0, 0, 100, 32, 32, 100, 64, 64, 100)); // collinear
    pending_ops.push_back(make_tri(-32768, -32768, 16384, 32767, -32768, 16384,
                                   -32768, 32767, 16384));
    pending_ops.push_back(make_plain(OPC_READ, 15, 0));
    pending_ops.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, 32767,
                                   -32768, 32767, -32768));
    pending_ops.push_back(make_tri(0, 0, -16384, 255, 0, 16384, 0, 255, 0));
    pending_ops.push_back(make_tri(-40, -40, 32767, 300, -40, 32767, -40, 300, 32767));
    pending_ops.push_back(make_plain(OPC_READ, 1, 1));
    pending_ops.push_back(make_plain(OPC_READ, 16, 3));
    pending_ops.push_back(make_plain(OPC_NOP, 255, 255));
    pending_ops.push_back(make_plain(OPC_CLEAR, 0, 0));
    pending_ops.push_back(make_plain(OPC_READ, 1, 1));
    pending_ops.push_back(make_tri(24, 24, 5, 24, 24, 5, 24, 24, 5));      // single point
    pending_ops.push_back(make_tri(200, 8, 0, 300, 8, 0, 250, 200, 0));    // crosses the right edge
    wait_idle();

    idle_mode = 0;
    write_reg(REG_WIDTH, 9'd256);
    write_reg(REG_HEIGHT, 9'd256);
    run_random(RANDOM_PER_PHASE, 1'b0);
    write_reg(REG_WIDTH, 9'd0);
    write_reg(REG_HEIGHT, 9'd300);
    run_random(RANDOM_PER_PHASE / 2, 1'b1);

    idle_mode = 1;
    write_reg(REG_WIDTH, 9'd37);
    write_reg(REG_HEIGHT, 9'd1);
    run_random(RANDOM_PER_PHASE / 2, 1'b1);
    write_reg(REG_WIDTH, 9'd511);
    write_reg(REG_HEIGHT, 9'd200);
    run_random(RANDOM_PER_PHASE / 2, 1'b0);

    idle_mode = 2;
    write_reg(REG_WIDTH, 9'd1);
    write_reg(REG_HEIGHT, 9'd256);
    run_random(RANDOM_PER_PHASE / 2, 1'b1);
    write_reg(REG_WIDTH, 9'd64);
    write_reg(REG_HEIGHT, 9'd48);
    run_random(RANDOM_PER_PHASE, 1'b0);

    repeat (100) @(posedge clk);
    $display("%0d operations sent over seven screen sizes: %0d draws, %0d reads,",
             sent_count, draws_seen, reads_seen);
    $display("%0d depth entries written in total", pixels_total);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
